// ===== rtl/mohr_coulomb_fracture_check_unit_macros.svh =====
// Assertion helpers for the file that checks its own logic.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef MOHR_COULOMB_FRACTURE_CHECK_UNIT_MACROS_SVH
`define MOHR_COULOMB_FRACTURE_CHECK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCF_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCF_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/mcf_pkg.sv =====
package mcf_pkg;

  localparam int STRESS_W   = 48;
  localparam int WEIGHT_W   = 17;
  localparam int TRIG_W     = 18;
  localparam int FRIC_W     = 21;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;
  localparam int SUMSQ_W    = 96;
  localparam int ROOT_W     = 48;

  localparam logic [1:0] OP_NODE   = 2'd0;
  localparam logic [1:0] OP_PAIR   = 2'd1;
  localparam logic [1:0] OP_TRIPLE = 2'd2;

  localparam logic [1:0] VERDICT_INTACT  = 2'd0;
  localparam logic [1:0] VERDICT_TENSILE = 2'd1;
  localparam logic [1:0] VERDICT_SHEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COHESION     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TENSILE      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_THETA    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_THETA    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SELF_WEIGHT  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OTHER_WEIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_WEIGHT = 4'd7;

  localparam logic [WEIGHT_W-1:0] Q_ONE    = 17'd65536;
  localparam logic [FRIC_W-1:0]   FRIC_MAX = 21'd1048576;

  // Data that rides alongside the sum of squares through the root pipeline.
  typedef struct packed {
    logic [1:0]                 op;
    logic signed [STRESS_W-1:0] first;
  } sqrt_side_t;

endpackage

// ===== rtl/mcf_in_if.sv =====
interface mcf_in_if import mcf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic signed [STRESS_W-1:0] a_sx;
  logic signed [STRESS_W-1:0] a_sy;
  logic signed [STRESS_W-1:0] a_sxy;
  logic signed [STRESS_W-1:0] b_sx;
  logic signed [STRESS_W-1:0] b_sy;
  logic signed [STRESS_W-1:0] b_sxy;
  logic signed [STRESS_W-1:0] c_sx;
  logic signed [STRESS_W-1:0] c_sy;
  logic signed [STRESS_W-1:0] c_sxy;

  modport source (output valid, operation, a_sx, a_sy, a_sxy, b_sx, b_sy, b_sxy,
                  c_sx, c_sy, c_sxy, input ready);
  modport sink (input valid, operation, a_sx, a_sy, a_sxy, b_sx, b_sy, b_sxy,
                c_sx, c_sy, c_sxy, output ready);
endinterface

// ===== rtl/mcf_out_if.sv =====
interface mcf_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

// ===== rtl/mcf_cfg_if.sv =====
interface mcf_cfg_if import mcf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mcf_sqrt_pipe.sv =====
// Integer square root, one result bit per register stage, most significant first.
module mcf_sqrt_pipe import mcf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [SUMSQ_W-1:0] in_num,
  input  sqrt_side_t         in_side,
  output logic               out_valid,
  output logic [ROOT_W-1:0]  out_root,
  output sqrt_side_t         out_side
);

  logic               vld_r  [1:ROOT_W];
  logic [SUMSQ_W-1:0] rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0]  root_r [1:ROOT_W];
  sqrt_side_t         side_r [1:ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic               vld_cur;
    logic [SUMSQ_W-1:0] rem_cur;
    logic [ROOT_W-1:0]  root_cur;
    sqrt_side_t         side_cur;
    logic [SUMSQ_W:0]   term;
    logic               take;
    logic [SUMSQ_W-1:0] rem_nxt;
    logic [ROOT_W-1:0]  root_nxt;

    if (i == 0) begin : g_head
      assign vld_cur  = in_valid;
      assign rem_cur  = in_num;
      assign root_cur = '0;
      assign side_cur = in_side;
    end else begin : g_body
      assign vld_cur  = vld_r[i];
      assign rem_cur  = rem_r[i];
      assign root_cur = root_r[i];
      assign side_cur = side_r[i];
    end

    // Growth of the square when bit K joins the root: q*2^(K+1) + 2^(2K).
    always_comb begin
      term     = ({{(SUMSQ_W + 1 - ROOT_W){1'b0}}, root_cur} << (K + 1))
               + ({{SUMSQ_W{1'b0}}, 1'b1} << (2 * K));
      take     = {1'b0, rem_cur} >= term;
      rem_nxt  = take ? rem_cur - term[SUMSQ_W-1:0] : rem_cur;
      root_nxt = root_cur | (take ? (ROOT_W'(1) << K) : '0);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_cur;
      end
      if (en) begin
        rem_r[i+1]  <= rem_nxt;
        root_r[i+1] <= root_nxt;
        side_r[i+1] <= side_cur;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_side  = side_r[ROOT_W];

endmodule

// ===== rtl/mohr_coulomb_fracture_check_unit.sv =====
// Channel  Role   Moves
// in_ch    sink   one request: operation and three stress triples
// out_ch   source one verdict per request, in request order
// cfg_ch   sink   one register write: index and data, always ready
//
// One request enters per cycle while no held result stalls out_ch; each passes six
// stages of blending and squaring, 48 stages of the bit-per-stage square root, and four
// stages for the plane stresses, friction product and final compares to reach out_ch.
// Reset is synchronous and clears all valid bits and the registers to defaults.
// A held result on out_ch freezes the whole pipeline; nothing is lost or repeated.
`include "mohr_coulomb_fracture_check_unit_macros.svh"

module mohr_coulomb_fracture_check_unit import mcf_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  mcf_in_if.sink   in_ch,
  mcf_out_if.source out_ch,
  mcf_cfg_if.sink  cfg_ch
);

  localparam logic signed [50:0] SAT_MAX = 51'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [50:0] SAT_MIN = -51'sh0_8000_0000_0000;
  localparam logic signed [TRIG_W-1:0] TRIG_POS = 18'sd65536;
  localparam logic signed [TRIG_W-1:0] TRIG_NEG = -18'sd65536;

  // Configuration registers.
  logic signed [STRESS_W-1:0] coh_r, ten_r;
  logic [FRIC_W-1:0]          fric_r;
  logic signed [TRIG_W-1:0]   sin_r, cos_r;
  logic [WEIGHT_W-1:0]        ws_r, wo_r, wc_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coh_r  <= '0;
      fric_r <= '0;
      ten_r  <= '0;
      sin_r  <= '0;
      cos_r  <= TRIG_POS;
      ws_r   <= Q_ONE;
      wo_r   <= '0;
      wc_r   <= Q_ONE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_COHESION:     coh_r  <= cfg_ch.data;
        REG_FRICTION:     fric_r <= cfg_ch.data[FRIC_W-1:0];
        REG_TENSILE:      ten_r  <= cfg_ch.data;
        REG_SIN_THETA:    sin_r  <= cfg_ch.data[TRIG_W-1:0];
        REG_COS_THETA:    cos_r  <= cfg_ch.data[TRIG_W-1:0];
        REG_SELF_WEIGHT:  ws_r   <= cfg_ch.data[WEIGHT_W-1:0];
        REG_OTHER_WEIGHT: wo_r   <= cfg_ch.data[WEIGHT_W-1:0];
        REG_THIRD_WEIGHT: wc_r   <= cfg_ch.data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Values as used: weights, trig and friction saturate.
  logic [WEIGHT_W-1:0]      ws_u, wo_u, wc_u;
  logic [FRIC_W-1:0]        fric_u;
  logic signed [TRIG_W-1:0] sin_u, cos_u;

  always_comb begin
    ws_u   = (ws_r > Q_ONE) ? Q_ONE : ws_r;
    wo_u   = (wo_r > Q_ONE) ? Q_ONE : wo_r;
    wc_u   = (wc_r > Q_ONE) ? Q_ONE : wc_r;
    fric_u = (fric_r > FRIC_MAX) ? FRIC_MAX : fric_r;
    sin_u  = (sin_r > TRIG_POS) ? TRIG_POS : ((sin_r < TRIG_NEG) ? TRIG_NEG : sin_r);
    cos_u  = (cos_r > TRIG_POS) ? TRIG_POS : ((cos_r < TRIG_NEG) ? TRIG_NEG : cos_r);
  end

  logic en;
  logic out_valid_r;
  logic [1:0] verdict_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: pick the two operand and weight pairs for each component.
  logic signed [STRESS_W-1:0] a_in [3], b_in [3], c_in [3];
  logic signed [STRESS_W-1:0] x0_nxt [3], x1_nxt [3];
  logic signed [WEIGHT_W:0]   w0_nxt, w1_nxt;
  logic signed [STRESS_W:0]   ab_sum [3];

  assign a_in[0] = in_ch.a_sx;
  assign a_in[1] = in_ch.a_sy;
  assign a_in[2] = in_ch.a_sxy;
  assign b_in[0] = in_ch.b_sx;
  assign b_in[1] = in_ch.b_sy;
  assign b_in[2] = in_ch.b_sxy;
  assign c_in[0] = in_ch.c_sx;
  assign c_in[1] = in_ch.c_sy;
  assign c_in[2] = in_ch.c_sxy;

  // A node check weighs a by exactly one and the second term by zero.
  always_comb begin
    case (in_ch.operation)
      OP_NODE: begin
        w0_nxt = {1'b0, Q_ONE};
        w1_nxt = '0;
      end
      OP_PAIR: begin
        w0_nxt = {1'b0, ws_u};
        w1_nxt = {1'b0, wo_u};
      end
      default: begin
        w0_nxt = {1'b0, Q_ONE - wc_u};
        w1_nxt = {1'b0, wc_u};
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      ab_sum[k] = {a_in[k][STRESS_W-1], a_in[k]} + {b_in[k][STRESS_W-1], b_in[k]};
      case (in_ch.operation)
        OP_NODE, OP_PAIR: begin
          x0_nxt[k] = a_in[k];
          x1_nxt[k] = b_in[k];
        end
        default: begin
          x0_nxt[k] = ab_sum[k][STRESS_W:1];
          x1_nxt[k] = c_in[k];
        end
      endcase
    end
  end

  logic                       v1_r;
  logic [1:0]                 op1_r;
  logic signed [STRESS_W-1:0] x0_r [3], x1_r [3];
  logic signed [WEIGHT_W:0]   w0_r, w1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
    if (en) begin
      op1_r <= in_ch.operation;
      w0_r  <= w0_nxt;
      w1_r  <= w1_nxt;
      for (int k = 0; k < 3; k++) begin
        x0_r[k] <= x0_nxt[k];
        x1_r[k] <= x1_nxt[k];
      end
    end
  end

  // Stage 2: weight products.
  logic                 v2_r;
  logic [1:0]           op2_r;
  logic signed [65:0]   p0_r [3], p1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      op2_r <= op1_r;
      for (int k = 0; k < 3; k++) begin
        p0_r[k] <= x0_r[k] * w0_r;
        p1_r[k] <= x1_r[k] * w1_r;
      end
    end
  end

  // Stage 3: floor each product to Q.16, add and saturate.
  logic signed [50:0]         bsum [3];
  logic signed [STRESS_W-1:0] s_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bsum[k] = {p0_r[k][65], p0_r[k][65:16]} + {p1_r[k][65], p1_r[k][65:16]};
      if (bsum[k] > SAT_MAX) begin
        s_nxt[k] = SAT_MAX[STRESS_W-1:0];
      end else if (bsum[k] < SAT_MIN) begin
        s_nxt[k] = SAT_MIN[STRESS_W-1:0];
      end else begin
        s_nxt[k] = bsum[k][STRESS_W-1:0];
      end
    end
  end

  logic                       v3_r;
  logic [1:0]                 op3_r;
  logic signed [STRESS_W-1:0] s_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      op3_r <= op2_r;
      for (int k = 0; k < 3; k++) begin
        s_r[k] <= s_nxt[k];
      end
    end
  end

  // Stage 4: mean, half difference and magnitudes for squaring.
  logic signed [STRESS_W:0]   sum01, dif01;
  logic signed [STRESS_W-1:0] half;
  logic [STRESS_W-1:0]        mh_nxt, ms_nxt;

  always_comb begin
    sum01  = {s_r[0][STRESS_W-1], s_r[0]} + {s_r[1][STRESS_W-1], s_r[1]};
    dif01  = {s_r[0][STRESS_W-1], s_r[0]} - {s_r[1][STRESS_W-1], s_r[1]};
    half   = dif01[STRESS_W:1];
    mh_nxt = half[STRESS_W-1] ? -half : half;
    ms_nxt = s_r[2][STRESS_W-1] ? -s_r[2] : s_r[2];
  end

  logic                       v4_r;
  logic [1:0]                 op4_r;
  logic signed [STRESS_W-1:0] first4_r;
  logic [STRESS_W-1:0]        mh_r, ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      op4_r    <= op3_r;
      first4_r <= sum01[STRESS_W:1];
      mh_r     <= mh_nxt;
      ms_r     <= ms_nxt;
    end
  end

  // Stage 5: squares split into partial products of 24 bit halves.
  localparam int HW = STRESS_W / 2;

  logic                       v5_r;
  logic [1:0]                 op5_r;
  logic signed [STRESS_W-1:0] first5_r;
  logic [2*HW-1:0]            hh_h_r, hl_h_r, ll_h_r, hh_s_r, hl_s_r, ll_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      op5_r    <= op4_r;
      first5_r <= first4_r;
      hh_h_r   <= mh_r[STRESS_W-1:HW] * mh_r[STRESS_W-1:HW];
      hl_h_r   <= mh_r[STRESS_W-1:HW] * mh_r[HW-1:0];
      ll_h_r   <= mh_r[HW-1:0] * mh_r[HW-1:0];
      hh_s_r   <= ms_r[STRESS_W-1:HW] * ms_r[STRESS_W-1:HW];
      hl_s_r   <= ms_r[STRESS_W-1:HW] * ms_r[HW-1:0];
      ll_s_r   <= ms_r[HW-1:0] * ms_r[HW-1:0];
    end
  end

  // Stage 6: assemble the sum of squares.
  logic [SUMSQ_W-1:0] num_nxt;

  always_comb begin
    num_nxt = ({hh_h_r, {(2*HW){1'b0}}} + ({{(SUMSQ_W-2*HW){1'b0}}, hl_h_r} << (HW + 1))
              + {{(SUMSQ_W-2*HW){1'b0}}, ll_h_r})
            + ({hh_s_r, {(2*HW){1'b0}}} + ({{(SUMSQ_W-2*HW){1'b0}}, hl_s_r} << (HW + 1))
              + {{(SUMSQ_W-2*HW){1'b0}}, ll_s_r});
  end

  logic               v6_r;
  logic [SUMSQ_W-1:0] num_r;
  sqrt_side_t         side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
    if (en) begin
      num_r         <= num_nxt;
      side6_r.op    <= op5_r;
      side6_r.first <= first5_r;
    end
  end

  logic              vq;
  logic [ROOT_W-1:0] root;
  sqrt_side_t        sideq;

  mcf_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_num    (num_r),
    .in_side   (side6_r),
    .out_valid (vq),
    .out_root  (root),
    .out_side  (sideq)
  );

  // Stage T1: principal stress and trig products.
  logic [WEIGHT_W-1:0] sin_m, cos_m;

  always_comb begin
    sin_m = sin_u[TRIG_W-1] ? WEIGHT_W'(-sin_u) : sin_u[WEIGHT_W-1:0];
    cos_m = cos_u[TRIG_W-1] ? WEIGHT_W'(-cos_u) : cos_u[WEIGHT_W-1:0];
  end

  logic                       vt1_r;
  logic [1:0]                 opt1_r;
  logic signed [STRESS_W-1:0] firstt1_r;
  logic signed [STRESS_W:0]   p2t1_r;
  logic [ROOT_W+WEIGHT_W-1:0] ps_r, pc_r;
  logic                       cneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt1_r <= 1'b0;
    end else if (en) begin
      vt1_r <= vq;
    end
    if (en) begin
      opt1_r    <= sideq.op;
      firstt1_r <= sideq.first;
      p2t1_r    <= {sideq.first[STRESS_W-1], sideq.first} + $signed({1'b0, root});
      ps_r      <= root * sin_m;
      pc_r      <= root * cos_m;
      cneg_r    <= cos_u[TRIG_W-1];
    end
  end

  // Stage T2: normal stress on the failure plane.
  localparam int TS_W = ROOT_W + WEIGHT_W - 16;

  logic signed [TS_W+1:0] tc;
  logic signed [TS_W+1:0] normal_nxt;

  always_comb begin
    tc = $signed({2'b00, pc_r[ROOT_W+WEIGHT_W-1:16]});
    normal_nxt = (TS_W + 2)'(firstt1_r) - (cneg_r ? -tc : tc);
  end

  logic                     vt2_r;
  logic [1:0]               opt2_r;
  logic signed [STRESS_W:0] p2t2_r;
  logic [TS_W-1:0]          shear_t2_r;
  logic signed [TS_W+1:0]   normal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt2_r <= 1'b0;
    end else if (en) begin
      vt2_r <= vt1_r;
    end
    if (en) begin
      opt2_r     <= opt1_r;
      p2t2_r     <= p2t1_r;
      shear_t2_r <= ps_r[ROOT_W+WEIGHT_W-1:16];
      normal_r   <= normal_nxt;
    end
  end

  // Stage T3: friction times normal, truncated in magnitude.
  localparam int NM_W = TS_W + 2;
  localparam int DN_W = NM_W + FRIC_W - 16;

  logic [NM_W-1:0]        nmag;
  logic [NM_W+FRIC_W-1:0] dprod;

  always_comb begin
    nmag  = normal_r[NM_W-1] ? -normal_r : normal_r;
    dprod = nmag * fric_u;
  end

  logic                     vt3_r;
  logic [1:0]               opt3_r;
  logic signed [STRESS_W:0] p2t3_r;
  logic [TS_W-1:0]          shear_t3_r;
  logic                     nneg_r;
  logic [DN_W-1:0]          dn_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt3_r <= 1'b0;
    end else if (en) begin
      vt3_r <= vt2_r;
    end
    if (en) begin
      opt3_r     <= opt2_r;
      p2t3_r     <= p2t2_r;
      shear_t3_r <= shear_t2_r;
      nneg_r     <= normal_r[NM_W-1];
      dn_mag_r   <= dprod[NM_W+FRIC_W-1:16];
    end
  end

  // Stage T4: compare against the shear limit and the tensile strength.
  logic signed [DN_W:0]   dn;
  logic signed [DN_W+1:0] lim;
  logic [DN_W+1:0]        lim_m;
  logic                   shear_fail;
  logic [1:0]             verdict_nxt;

  always_comb begin
    dn    = nneg_r ? -$signed({1'b0, dn_mag_r}) : $signed({1'b0, dn_mag_r});
    lim   = (DN_W + 2)'(coh_r) - (DN_W + 2)'(dn);
    lim_m = lim[DN_W+1] ? -lim : lim;
    shear_fail = ({{(DN_W + 2 - TS_W){1'b0}}, shear_t3_r} >= lim_m)
               && (opt3_r == OP_NODE || nneg_r);
    if (shear_fail) begin
      verdict_nxt = VERDICT_SHEAR;
    end else if (p2t3_r >= (STRESS_W + 1)'(ten_r)) begin
      verdict_nxt = VERDICT_TENSILE;
    end else begin
      verdict_nxt = VERDICT_INTACT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vt3_r;
    end
    if (en) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.verdict = verdict_r;

  `MCF_ASSERT_NXT(a_accept_enters, in_ch.valid && in_ch.ready, v1_r, "accepted request missing in first stage")
  `MCF_ASSERT_NXT(a_stall_freeze, !en, $stable(v1_r) && $stable(v6_r) && $stable(vt3_r), "pipeline moved during a stall")
  `MCF_ASSERT_IMP(a_verdict_code, out_valid_r, verdict_r == VERDICT_INTACT || verdict_r == VERDICT_TENSILE || verdict_r == VERDICT_SHEAR, "undefined verdict code")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mcf_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0]                 op;
    logic signed [STRESS_W-1:0] a [3];
    logic signed [STRESS_W-1:0] b [3];
    logic signed [STRESS_W-1:0] c [3];
  } stress_req_t;

  class verdict_board;
    logic [1:0]                 pending_verdicts [$];
    int                         errors;
    int                         checked;
    logic signed [STRESS_W-1:0] cohesion;
    logic [FRIC_W-1:0]          friction;
    logic signed [STRESS_W-1:0] tensile;
    logic signed [TRIG_W-1:0]   sin_t;
    logic signed [TRIG_W-1:0]   cos_t;
    logic [WEIGHT_W-1:0]        w_self;
    logic [WEIGHT_W-1:0]        w_other;
    logic [WEIGHT_W-1:0]        w_third;

    function new();
      errors = 0;
      checked = 0;
      cohesion = '0;
      friction = '0;
      tensile = '0;
      sin_t = '0;
      cos_t = 18'sd65536;
      w_self = Q_ONE;
      w_other = '0;
      w_third = Q_ONE;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COHESION:     cohesion = data[STRESS_W-1:0];
        REG_FRICTION:     friction = data[FRIC_W-1:0];
        REG_TENSILE:      tensile = data[STRESS_W-1:0];
        REG_SIN_THETA:    sin_t = data[TRIG_W-1:0];
        REG_COS_THETA:    cos_t = data[TRIG_W-1:0];
        REG_SELF_WEIGHT:  w_self = data[WEIGHT_W-1:0];
        REG_OTHER_WEIGHT: w_other = data[WEIGHT_W-1:0];
        REG_THIRD_WEIGHT: w_third = data[WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function wide_t magnitude(wide_t x);
      return (x < 0) ? -x : x;
    endfunction

    function wide_t clamp(wide_t x, wide_t lo, wide_t hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Product with a Q1.16 trig value, truncated in magnitude.
    function wide_t trig_part(wide_t root, wide_t t);
      wide_t m;
      m = (root * magnitude(t)) >>> 16;
      return (t < 0) ? -m : m;
    endfunction

    function logic [1:0] fracture_verdict(stress_req_t r);
      wide_t coh, ten, sn, cs, ws, wo, wc, fr;
      wide_t av, bv, cv, mid, first, half, sumsq, root, cand, p2;
      wide_t shear_mag, normal, dn, lim;
      wide_t s [3];
      logic shear_fail;
      coh = cohesion;
      ten = tensile;
      sn = clamp(sin_t, -65536, 65536);
      cs = clamp(cos_t, -65536, 65536);
      ws = clamp(w_self, 0, 65536);
      wo = clamp(w_other, 0, 65536);
      wc = clamp(w_third, 0, 65536);
      fr = clamp(friction, 0, 1048576);
      for (int k = 0; k < 3; k++) begin
        av = r.a[k];
        bv = r.b[k];
        cv = r.c[k];
        if (r.op == OP_NODE) begin
          s[k] = av;
        end else if (r.op == OP_PAIR) begin
          s[k] = ((av * ws) >>> 16) + ((bv * wo) >>> 16);
        end else begin
          mid = (av + bv) >>> 1;
          s[k] = ((mid * (65536 - wc)) >>> 16) + ((cv * wc) >>> 16);
        end
        s[k] = clamp(s[k], -(wide_t'(1) <<< 47), (wide_t'(1) <<< 47) - 1);
      end
      first = (s[0] + s[1]) >>> 1;
      half = (s[0] - s[1]) >>> 1;
      sumsq = half * half + s[2] * s[2];
      root = 0;
      for (int bit_pos = 48; bit_pos >= 0; bit_pos--) begin
        cand = root | (wide_t'(1) <<< bit_pos);
        if (cand * cand <= sumsq) root = cand;
      end
      p2 = first + root;
      shear_mag = magnitude(trig_part(root, sn));
      normal = first - trig_part(root, cs);
      dn = (magnitude(normal) * fr) >>> 16;
      if (normal < 0) dn = -dn;
      lim = magnitude(coh - dn);
      shear_fail = (shear_mag >= lim);
      if (r.op != OP_NODE && normal >= 0) shear_fail = 1'b0;
      if (shear_fail) return VERDICT_SHEAR;
      if (p2 >= ten) return VERDICT_TENSILE;
      return VERDICT_INTACT;
    endfunction

    function void note_request(stress_req_t r);
      pending_verdicts.insert(pending_verdicts.size(), fracture_verdict(r));
    endfunction

    function void check_verdict(logic [1:0] got);
      logic [1:0] want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict %0d arrived with no request outstanding", $time, got);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function bit idle();
      return pending_verdicts.size() == 0;
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 64;

  logic clk;
  logic rst_n;
  int   cycles;
  int   stall_mode;
  int   stall_left;

  mcf_in_if  in_ch ();
  mcf_out_if out_ch ();
  mcf_cfg_if cfg_ch ();

  mohr_coulomb_fracture_check_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  verdict_board board = new();

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Observers see the values that stood before the edge.
  always @(posedge clk) begin
    stress_req_t r;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        r.op = in_ch.operation;
        r.a[0] = in_ch.a_sx;  r.a[1] = in_ch.a_sy;  r.a[2] = in_ch.a_sxy;
        r.b[0] = in_ch.b_sx;  r.b[1] = in_ch.b_sy;  r.b[2] = in_ch.b_sxy;
        r.c[0] = in_ch.c_sx;  r.c[1] = in_ch.c_sy;  r.c[2] = in_ch.c_sxy;
        board.note_request(r);
      end
      if (out_ch.valid && out_ch.ready) board.check_verdict(out_ch.verdict);
      if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // Receiver: mode 0 never stalls, mode 1 stalls at random, mode 2 takes long pauses.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_mode == 1) begin
      out_ch.ready <= ($urandom_range(0, 99) < 65);
    end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(1, 20);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic signed [STRESS_W-1:0] rand_stress();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return raw[STRESS_W-1:0];
      1: return {1'b0, {(STRESS_W-1){1'b1}}};
      2: return {1'b1, {(STRESS_W-1){1'b0}}};
      3: return 48'(signed'(raw[23:0]));
      4: return '0;
      5: return 48'(signed'(raw[39:0]));
      default: return 48'(signed'(raw[31:0]));
    endcase
  endfunction

  function automatic stress_req_t rand_req();
    stress_req_t r;
    r.op = 2'($urandom_range(0, 3));
    for (int k = 0; k < 3; k++) begin
      r.a[k] = rand_stress();
      r.b[k] = rand_stress();
      r.c[k] = rand_stress();
    end
    return r;
  endfunction

  function automatic stress_req_t uniform_req(logic [1:0] op, logic signed [STRESS_W-1:0] v);
    stress_req_t r;
    r.op = op;
    for (int k = 0; k < 3; k++) begin
      r.a[k] = v;
      r.b[k] = v;
      r.c[k] = v;
    end
    return r;
  endfunction

  task automatic send_request(stress_req_t r);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= r.op;
    in_ch.a_sx <= r.a[0];  in_ch.a_sy <= r.a[1];  in_ch.a_sxy <= r.a[2];
    in_ch.b_sx <= r.b[0];  in_ch.b_sy <= r.b[1];  in_ch.b_sxy <= r.b[2];
    in_ch.c_sx <= r.c[0];  in_ch.c_sy <= r.c[1];  in_ch.c_sxy <= r.c[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (!board.idle()) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_all(logic [CFG_DATA_W-1:0] coh, logic [CFG_DATA_W-1:0] fric,
                             logic [CFG_DATA_W-1:0] ten, logic [CFG_DATA_W-1:0] sn,
                             logic [CFG_DATA_W-1:0] cs, logic [CFG_DATA_W-1:0] ws,
                             logic [CFG_DATA_W-1:0] wo, logic [CFG_DATA_W-1:0] wc);
    write_register(REG_COHESION, coh);
    write_register(REG_FRICTION, fric);
    write_register(REG_TENSILE, ten);
    write_register(REG_SIN_THETA, sn);
    write_register(REG_COS_THETA, cs);
    write_register(REG_SELF_WEIGHT, ws);
    write_register(REG_OTHER_WEIGHT, wo);
    write_register(REG_THIRD_WEIGHT, wc);
    // An index past the last register must leave everything untouched.
    write_register(CFG_IDX_W'($urandom_range(8, 15)), {$urandom, $urandom});
  endtask

  task automatic random_traffic(int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(rand_req());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_field(int width, int lo, int hi);
    if ($urandom_range(0, 4) == 0) return CFG_DATA_W'($urandom & ((1 << width) - 1));
    return CFG_DATA_W'($urandom_range(hi, lo));
  endfunction

  initial begin
    stress_req_t r;
    cycles = 0;
    stall_mode = 0;
    stall_left = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.a_sx = '0;  in_ch.a_sy = '0;  in_ch.a_sxy = '0;
    in_ch.b_sx = '0;  in_ch.b_sy = '0;  in_ch.b_sxy = '0;
    in_ch.c_sx = '0;  in_ch.c_sy = '0;  in_ch.c_sxy = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset settings.
    for (int op = 0; op < 4; op++) begin
      send_request(uniform_req(2'(op), {1'b0, {(STRESS_W-1){1'b1}}}));
      send_request(uniform_req(2'(op), {1'b1, {(STRESS_W-1){1'b0}}}));
      send_request(uniform_req(2'(op), '0));
    end
    r = uniform_req(OP_NODE, '0);
    r.a[0] = {1'b0, {(STRESS_W-1){1'b1}}};
    r.a[1] = {1'b1, {(STRESS_W-1){1'b0}}};
    r.a[2] = {1'b1, {(STRESS_W-1){1'b0}}};
    send_request(r);
    r.op = OP_PAIR;
    send_request(r);
    r.op = OP_TRIPLE;
    r.c[2] = {1'b0, {(STRESS_W-1){1'b1}}};
    send_request(r);
    // Tension and compression for a node, with the shear equal to the normal stresses.
    r = uniform_req(OP_NODE, 48'sd65536);
    send_request(r);
    r = uniform_req(OP_NODE, -48'sd65536);
    send_request(r);
    r = uniform_req(OP_PAIR, -48'sd655360);
    r.a[2] = 48'sd1000;
    send_request(r);
    drain();

    // Extremes: saturating weights, trig and friction beyond their range.
    program_all({1'b0, {47{1'b1}}}, 48'h1FFFFF, {1'b0, {47{1'b1}}}, 48'h1FFFF,
                48'h1FFFF, 48'h1FFFF, 48'h1FFFF, 48'h1FFFF);
    send_request(uniform_req(OP_PAIR, {1'b0, {(STRESS_W-1){1'b1}}}));
    send_request(uniform_req(OP_TRIPLE, {1'b1, {(STRESS_W-1){1'b0}}}));
    drain();
    program_all({1'b1, {47{1'b0}}}, '0, {1'b1, {47{1'b0}}}, 48'h20000,
                48'h20000, '0, '0, '0);
    send_request(uniform_req(OP_TRIPLE, {1'b0, {(STRESS_W-1){1'b1}}}));
    send_request(uniform_req(OP_NODE, -48'sd1));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      stall_mode = phase % 3;
      if (phase == 0) begin
        program_all({1'b0, {47{1'b1}}}, 48'd1048576, {1'b0, {47{1'b1}}}, 48'd65536,
                    48'h3_0000, 48'd65536, 48'd65536, 48'd65536);
      end else if (phase == 1) begin
        program_all({1'b1, {47{1'b0}}}, '0, {1'b1, {47{1'b0}}}, 48'h3_0000,
                    48'd65536, '0, '0, '0);
      end else begin
        program_all(CFG_DATA_W'(rand_stress()), rand_field(FRIC_W, 0, 1048576),
                    CFG_DATA_W'(rand_stress()),
                    CFG_DATA_W'(18'($urandom_range(0, 131072) - 65536)),
                    CFG_DATA_W'(18'($urandom_range(0, 131072) - 65536)),
                    rand_field(WEIGHT_W, 0, 65536), rand_field(WEIGHT_W, 0, 65536),
                    rand_field(WEIGHT_W, 0, 65536));
      end
      random_traffic(250);
      drain();
    end

    $display("Checked %0d verdicts across node, pair and three point requests,", board.checked);
    $display("under reset, extreme, saturating and random register settings.");
    if (board.errors == 0 && board.idle()) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
